// ===== rtl/atcb_pkg.sv =====
// ----------------------------------------------------------------------------
// atcb_pkg
// Shared types, widths and constants for the accelerating two-color blinker.
// ----------------------------------------------------------------------------
package atcb_pkg;

  // field widths
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned IVL_W     = 16;
  localparam int unsigned FAST_W    = 9;
  localparam int unsigned COLOR_W   = 2;
  localparam int unsigned CFG_AW    = 2;
  localparam int unsigned CFG_DW    = 32;
  localparam int unsigned OUT_DW    = 32;

  // arithmetic widths
  localparam int unsigned MUL_BW    = 24;
  localparam int unsigned MUL_PW    = TIME_W + MUL_BW;
  localparam int unsigned PROD_W    = 47;
  localparam int unsigned DVD_W     = 39;
  localparam int unsigned QUO_W     = 7;
  localparam int unsigned DSH_W     = TIME_W + QUO_W - 1;
  localparam int unsigned CNT_W     = 3;
  localparam int unsigned SLPROD_W  = 23;

  // constants
  localparam logic [IVL_W-1:0]  MID_INTERVAL = 16'd400;
  localparam logic [PCT_W-1:0]  FULL_PCT     = 7'd100;
  localparam logic [MUL_BW-1:0] PCT_SCALE    = 24'd100;
  // ceil(2^30 / 100), exact x/100 for x below 2^23
  localparam logic [MUL_BW-1:0] RECIP_100    = 24'd10737419;
  localparam int unsigned       RECIP_SH     = 30;

  // operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_DURATION = 2'd0;
  localparam logic [CFG_AW-1:0] REG_RED_PCT  = 2'd1;
  localparam logic [CFG_AW-1:0] REG_SLOWEST  = 2'd2;
  localparam logic [CFG_AW-1:0] REG_FASTEST  = 2'd3;

  typedef enum logic [COLOR_W-1:0] {
    COLOR_OFF   = 2'd0,
    COLOR_RED   = 2'd1,
    COLOR_GREEN = 2'd2
  } color_t;

  typedef enum logic [1:0] {
    RUN_IDLE   = 2'd0,
    RUN_ACTIVE = 2'd1,
    RUN_DONE   = 2'd2
  } run_t;

  typedef enum logic [1:0] {
    MUL_ELAPSED,
    MUL_PHASE,
    MUL_SLIDE,
    MUL_RECIP
  } mul_sel_t;

  typedef enum logic {
    DIV_PROGRESS,
    DIV_PHASE
  } div_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_PDIV,
    S_PWAIT,
    S_IVMUL,
    S_IVDIV,
    S_IVWAIT,
    S_SLMUL,
    S_SLRECIP,
    S_SLFIN,
    S_TOGGLE,
    S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic     cap_in;
    logic     do_start;
    logic     do_complete;
    logic     hold_done;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     div_start;
    div_sel_t div_sel;
    logic     prog_ld;
    logic     p_ld;
    logic     ivl_ld;
    logic     toggle_chk;
    logic     out_ld;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op;
    logic run_done;
    logic elapsed_ge;
    logic p_fixed;
    logic div_done;
  } sts_t;

endpackage

// ===== rtl/accelerating_two_color_blinker_top.sv =====
// ----------------------------------------------------------------------------
// accelerating_two_color_blinker_top
// LED blinker that speeds up over a timed progress action, red then green.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: in_tuser selects start (0) or step (1), in_tdata carries the
//   millisecond timestamp. Each input transfer yields exactly one result
//   transfer on the output stream with the LED color, lit flag, finished flag,
//   progress percent and blink interval.
//   Work per item: a start runs the interval steps; a running step first
//   computes progress percent and ends with the toggle check; a step that
//   completes or follows completion goes straight to the result. Up to two
//   divider runs (seven quotient bits each, for progress percent and phase
//   fraction) and the multiply steps on the shared multiplier do the work.
//   One item is in work at a time; the next is taken once its result is loaded.
//   The result sits in an output register; while the receiver stalls, the
//   next item is still taken and worked on up to the point of loading it.
//   Reset (rst_n low, synchronous) clears the run state, LED state and
//   timestamps and loads the configuration defaults: 5000 ms duration, 50
//   percent red phase, 1000 ms slowest and 50 ms fastest interval. The user
//   must write configuration via cfg_we/cfg_addr/cfg_wdata only while idle.
// ----------------------------------------------------------------------------
module accelerating_two_color_blinker_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [atcb_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [atcb_pkg::CFG_DW-1:0]  cfg_wdata,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [atcb_pkg::TIME_W-1:0]  in_tdata,   // [31:0] now_ms
  input  logic                         in_tuser,   // [0] operation
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [1:0] led_color, [2] led_on, [3] finished, [10:4] progress_percent,
  // [26:11] blink_interval_ms, [31:27] zero
  output logic [atcb_pkg::OUT_DW-1:0]  out_tdata
);

  atcb_pkg::cmd_t cmd;
  atcb_pkg::sts_t sts;

  atcb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  atcb_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== rtl/atcb_div.sv =====
// ----------------------------------------------------------------------------
// atcb_div
// Restoring divider, one quotient bit per cycle; quotient known below 128.
// ----------------------------------------------------------------------------
module atcb_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [atcb_pkg::DVD_W-1:0]     dividend,
  input  logic [atcb_pkg::TIME_W-1:0]    divisor,
  output logic [atcb_pkg::QUO_W-1:0]     quotient,
  output logic                           done
);

  logic [atcb_pkg::DVD_W-1:0] rem_r;
  logic [atcb_pkg::DSH_W-1:0] dsh_r;
  logic [atcb_pkg::QUO_W-1:0] q_r;
  logic [atcb_pkg::CNT_W-1:0] cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [atcb_pkg::DVD_W-1:0] dsh_ext;
  logic                       ge;

  // trial subtract of the shifted divisor
  assign dsh_ext = {{(atcb_pkg::DVD_W-atcb_pkg::DSH_W){1'b0}}, dsh_r};
  assign ge      = (rem_r >= dsh_ext);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= atcb_pkg::CNT_W'(atcb_pkg::QUO_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - atcb_pkg::CNT_W'(1);
        end
      end
    end
  end

  // remainder, divisor and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      dsh_r <= {divisor, {(atcb_pkg::QUO_W-1){1'b0}}};
    end else if (busy_r) begin
      rem_r <= ge ? (rem_r - dsh_ext) : rem_r;
      dsh_r <= dsh_r >> 1;
      q_r   <= {q_r[atcb_pkg::QUO_W-2:0], ge};
    end
  end

  assign quotient = q_r;
  assign done     = done_r;

  // checks
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("divider done held longer than one cycle");

  a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (q_r < atcb_pkg::FULL_PCT))
    else $error("divider quotient reached full percent");

endmodule

// ===== rtl/atcb_dp.sv =====
// ----------------------------------------------------------------------------
// atcb_dp
// Datapath: config registers, blinker state, shared multiplier, divider
// and result register.
// ----------------------------------------------------------------------------
module atcb_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [atcb_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [atcb_pkg::CFG_DW-1:0]  cfg_wdata,
  input  logic [atcb_pkg::TIME_W-1:0]  in_tdata,
  input  logic                         in_tuser,
  output logic [atcb_pkg::OUT_DW-1:0]  out_tdata,
  input  atcb_pkg::cmd_t               cmd,
  output atcb_pkg::sts_t               sts
);

  // config registers
  logic [atcb_pkg::TIME_W-1:0] duration_r;
  logic [atcb_pkg::PCT_W-1:0]  red_pct_r;
  logic [atcb_pkg::IVL_W-1:0]  slowest_r;
  logic [atcb_pkg::FAST_W-1:0] fastest_r;

  // blinker state
  atcb_pkg::run_t              run_r;
  atcb_pkg::color_t            color_r;
  logic                        lit_r;
  logic [atcb_pkg::TIME_W-1:0] start_r;
  logic [atcb_pkg::TIME_W-1:0] last_r;

  // per item working registers
  logic                        op_r;
  logic [atcb_pkg::TIME_W-1:0] now_r;
  logic                        fin_r;
  logic [atcb_pkg::PCT_W-1:0]  prog_r;
  logic [atcb_pkg::PCT_W-1:0]  p_r;
  logic [atcb_pkg::IVL_W-1:0]  ivl_r;
  logic [atcb_pkg::PROD_W-1:0] prod_r;

  // result register
  logic [atcb_pkg::OUT_DW-1:0] out_data_r;

  logic [atcb_pkg::TIME_W-1:0] elapsed;
  logic                        green;
  logic [atcb_pkg::PCT_W-1:0]  ph_num;
  logic [atcb_pkg::PCT_W-1:0]  ph_den;
  logic [atcb_pkg::IVL_W-1:0]  sl_a;
  logic [atcb_pkg::IVL_W-1:0]  sl_b;
  logic                        sl_desc;
  logic [atcb_pkg::IVL_W-1:0]  sl_diff;
  logic [atcb_pkg::IVL_W-1:0]  sl_q;
  logic [atcb_pkg::IVL_W-1:0]  sl_ivl;
  logic [atcb_pkg::IVL_W-1:0]  fast_ext;
  logic [atcb_pkg::TIME_W-1:0] mul_a;
  logic [atcb_pkg::MUL_BW-1:0] mul_b;
  logic [atcb_pkg::MUL_PW-1:0] mul_p;
  logic [atcb_pkg::TIME_W-1:0] div_den;
  logic [atcb_pkg::QUO_W-1:0]  quo;
  logic                        div_done;
  logic                        tog_due;

  // config write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duration_r <= 32'd5000;
      red_pct_r  <= 7'd50;
      slowest_r  <= 16'd1000;
      fastest_r  <= 9'd50;
    end else if (cfg_we) begin
      case (cfg_addr)
        atcb_pkg::REG_DURATION: duration_r <= cfg_wdata;
        atcb_pkg::REG_RED_PCT:  red_pct_r  <= cfg_wdata[atcb_pkg::PCT_W-1:0];
        atcb_pkg::REG_SLOWEST:  slowest_r  <= cfg_wdata[atcb_pkg::IVL_W-1:0];
        atcb_pkg::REG_FASTEST:  fastest_r  <= cfg_wdata[atcb_pkg::FAST_W-1:0];
        default: ;
      endcase
    end
  end

  // elapsed time and phase selection
  assign elapsed  = (run_r == atcb_pkg::RUN_ACTIVE) ? (now_r - start_r) : '0;
  assign green    = (prog_r >= red_pct_r);
  assign ph_num   = green ? (prog_r - red_pct_r) : prog_r;
  assign ph_den   = green ? (atcb_pkg::FULL_PCT - red_pct_r) : red_pct_r;
  assign fast_ext = {{(atcb_pkg::IVL_W-atcb_pkg::FAST_W){1'b0}}, fastest_r};

  // slide ends and direction
  assign sl_a    = green ? atcb_pkg::MID_INTERVAL : slowest_r;
  assign sl_b    = green ? fast_ext : atcb_pkg::MID_INTERVAL;
  assign sl_desc = (sl_a >= sl_b);
  assign sl_diff = sl_desc ? (sl_a - sl_b) : (sl_b - sl_a);
  assign sl_q    = prod_r[atcb_pkg::RECIP_SH +: atcb_pkg::IVL_W];
  assign sl_ivl  = sl_desc ? (sl_a - sl_q) : (sl_a + sl_q);

  // shared multiplier operands
  always_comb begin
    case (cmd.mul_sel)
      atcb_pkg::MUL_ELAPSED: begin
        mul_a = elapsed;
        mul_b = atcb_pkg::PCT_SCALE;
      end
      atcb_pkg::MUL_PHASE: begin
        mul_a = atcb_pkg::TIME_W'(ph_num);
        mul_b = atcb_pkg::PCT_SCALE;
      end
      atcb_pkg::MUL_SLIDE: begin
        mul_a = atcb_pkg::TIME_W'(sl_diff);
        mul_b = atcb_pkg::MUL_BW'(p_r);
      end
      atcb_pkg::MUL_RECIP: begin
        mul_a = atcb_pkg::TIME_W'(prod_r[atcb_pkg::SLPROD_W-1:0]);
        mul_b = atcb_pkg::RECIP_100;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = atcb_pkg::MUL_PW'(mul_a) * atcb_pkg::MUL_PW'(mul_b);

  // divisor select
  assign div_den = (cmd.div_sel == atcb_pkg::DIV_PROGRESS) ? duration_r
                                                           : atcb_pkg::TIME_W'(ph_den);

  atcb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_r[atcb_pkg::DVD_W-1:0]),
    .divisor  (div_den),
    .quotient (quo),
    .done     (div_done)
  );

  // toggle when the interval has passed since the last toggle
  assign tog_due = ((now_r - last_r) >= atcb_pkg::TIME_W'(ivl_r));

  // blinker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= atcb_pkg::RUN_IDLE;
      color_r <= atcb_pkg::COLOR_OFF;
      lit_r   <= 1'b0;
      start_r <= '0;
      last_r  <= '0;
    end else begin
      if (cmd.do_start) begin
        run_r   <= atcb_pkg::RUN_ACTIVE;
        color_r <= atcb_pkg::COLOR_OFF;
        lit_r   <= 1'b0;
        start_r <= now_r;
        last_r  <= now_r;
      end else if (cmd.do_complete) begin
        run_r   <= atcb_pkg::RUN_DONE;
        color_r <= atcb_pkg::COLOR_GREEN;
        lit_r   <= 1'b1;
      end else if (cmd.toggle_chk && tog_due) begin
        last_r <= now_r;
        if (lit_r) begin
          color_r <= atcb_pkg::COLOR_OFF;
          lit_r   <= 1'b0;
        end else begin
          color_r <= green ? atcb_pkg::COLOR_GREEN : atcb_pkg::COLOR_RED;
          lit_r   <= 1'b1;
        end
      end
    end
  end

  // per item working registers
  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      op_r  <= in_tuser;
      now_r <= in_tdata;
      fin_r <= 1'b0;
    end
    if (cmd.do_start) begin
      prog_r <= '0;
    end
    if (cmd.do_complete || cmd.hold_done) begin
      fin_r  <= 1'b1;
      prog_r <= atcb_pkg::FULL_PCT;
      ivl_r  <= fast_ext;
    end
    if (cmd.prog_ld) begin
      prog_r <= quo;
    end
    if (cmd.p_ld) begin
      p_r <= sts.p_fixed ? atcb_pkg::FULL_PCT : quo;
    end
    if (cmd.ivl_ld) begin
      ivl_r <= sl_ivl;
    end
    if (cmd.mul_en) begin
      prod_r <= mul_p[atcb_pkg::PROD_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_data_r <= {{(atcb_pkg::OUT_DW-27){1'b0}}, ivl_r, prog_r, fin_r, lit_r,
                     color_r};
    end
  end

  assign out_tdata = out_data_r;

  // status to controller
  assign sts.op         = op_r;
  assign sts.run_done   = (run_r == atcb_pkg::RUN_DONE);
  assign sts.elapsed_ge = (elapsed >= duration_r);
  assign sts.p_fixed    = green && (red_pct_r >= atcb_pkg::FULL_PCT);
  assign sts.div_done   = div_done;

endmodule

// ===== rtl/atcb_ctrl.sv =====
// ----------------------------------------------------------------------------
// atcb_ctrl
// Sequencer for one item: decide, progress, interval, toggle, result.
// ----------------------------------------------------------------------------
module atcb_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  atcb_pkg::sts_t  sts,
  output atcb_pkg::cmd_t  cmd
);

  atcb_pkg::state_t state_r;
  atcb_pkg::state_t state_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;

  // state and result valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= atcb_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.mul_sel = atcb_pkg::MUL_ELAPSED;
    cmd.div_sel = atcb_pkg::DIV_PROGRESS;
    in_tready   = 1'b0;
    case (state_r)
      atcb_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.cap_in = 1'b1;
          state_nxt  = atcb_pkg::S_DECIDE;
        end
      end
      atcb_pkg::S_DECIDE: begin
        if (sts.op == atcb_pkg::OP_START) begin
          cmd.do_start = 1'b1;
          state_nxt    = atcb_pkg::S_IVMUL;
        end else if (sts.run_done) begin
          cmd.hold_done = 1'b1;
          state_nxt     = atcb_pkg::S_OUT;
        end else if (sts.elapsed_ge) begin
          cmd.do_complete = 1'b1;
          state_nxt       = atcb_pkg::S_OUT;
        end else begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = atcb_pkg::MUL_ELAPSED;
          state_nxt   = atcb_pkg::S_PDIV;
        end
      end
      atcb_pkg::S_PDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = atcb_pkg::DIV_PROGRESS;
        state_nxt     = atcb_pkg::S_PWAIT;
      end
      atcb_pkg::S_PWAIT: begin
        if (sts.div_done) begin
          cmd.prog_ld = 1'b1;
          state_nxt   = atcb_pkg::S_IVMUL;
        end
      end
      atcb_pkg::S_IVMUL: begin
        if (sts.p_fixed) begin
          cmd.p_ld  = 1'b1;
          state_nxt = atcb_pkg::S_SLMUL;
        end else begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = atcb_pkg::MUL_PHASE;
          state_nxt   = atcb_pkg::S_IVDIV;
        end
      end
      atcb_pkg::S_IVDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = atcb_pkg::DIV_PHASE;
        state_nxt     = atcb_pkg::S_IVWAIT;
      end
      atcb_pkg::S_IVWAIT: begin
        cmd.div_sel = atcb_pkg::DIV_PHASE;
        if (sts.div_done) begin
          cmd.p_ld  = 1'b1;
          state_nxt = atcb_pkg::S_SLMUL;
        end
      end
      atcb_pkg::S_SLMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = atcb_pkg::MUL_SLIDE;
        state_nxt   = atcb_pkg::S_SLRECIP;
      end
      atcb_pkg::S_SLRECIP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = atcb_pkg::MUL_RECIP;
        state_nxt   = atcb_pkg::S_SLFIN;
      end
      atcb_pkg::S_SLFIN: begin
        cmd.ivl_ld = 1'b1;
        state_nxt  = (sts.op == atcb_pkg::OP_STEP) ? atcb_pkg::S_TOGGLE
                                                   : atcb_pkg::S_OUT;
      end
      atcb_pkg::S_TOGGLE: begin
        cmd.toggle_chk = 1'b1;
        state_nxt      = atcb_pkg::S_OUT;
      end
      atcb_pkg::S_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_ld = 1'b1;
          state_nxt  = atcb_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = atcb_pkg::S_IDLE;
      end
    endcase
  end

  // result valid: set on load, cleared on transfer
  assign out_valid_nxt = cmd.out_ld ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  assign out_tvalid    = out_valid_r;

endmodule
